// File: rtl/uct_pkg.sv
// Types and codes shared by the unique color table modules.
`timescale 1ns / 1ps

package uct_pkg;

  // Operation carried by a request.
  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_READ_ONLY = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] color;
    logic [7:0]  index;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  found_index;
    logic [8:0]  entry_count;
  } out_item_t;

  // Per-cell write controls from the controller.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/uct_cell.sv
// One table cell: holds an entry and passes the running match result to its neighbor.
`timescale 1ns / 1ps

module uct_cell import uct_pkg::*; #(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [31:0]      key,
  input  logic [31:0]      next_color,
  input  logic             live,
  input  logic             hit_in,
  input  logic [IDX_W-1:0] idx_in,
  output logic             hit_out,
  output logic [IDX_W-1:0] idx_out,
  output logic [31:0]      color_out
);

  logic [31:0]      color_r;
  logic             hit_r;
  logic [IDX_W-1:0] idx_r;
  logic             match;

  assign match = live && (color_r == key);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      color_r <= key;
    end else if (ctl.shift) begin
      color_r <= next_color;
    end
  end

  // An earlier hit from upstream wins, so the lowest index survives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_in | match;
    end
    idx_r <= hit_in ? idx_in : IDX_W'(CELL_IDX);
  end

  assign hit_out   = hit_r;
  assign idx_out   = idx_r;
  assign color_out = color_r;

endmodule

// File: rtl/unique_color_table.sv
// Top level of the unique color table: request controller and the chain of cells.
`timescale 1ns / 1ps

// The table holds up to TABLE_DEPTH distinct 32-bit colors in a row of cells,
// one entry per cell, packed from index zero. A request is a search, an insert,
// a remove at an index, or a clear, and every request returns exactly one
// result with a status, the matching index where one applies, and the entry
// count after the operation. Searches, and inserts while the table is writable,
// compare the key in every cell at once, and the hit flag then ripples through
// the chain one cell per clock so that the lowest matching index wins. That
// ripple sets the cost of those two requests: they stay in the scan state until
// the hit has crossed the whole chain. Removes, clears and requests refused by
// the read-only register skip the scan and go straight to the response state.
// A remove shifts every later entry down by one, all on the same clock edge.
// The block works on one request at a time, but it takes the next request
// while the previous result still waits in the output register; a finished
// request that finds that register still occupied stays in the response state
// until the result side takes the older result. The read_only register is
// written through the cfg_ channel, which is always ready; write it only while
// no request is in flight. Entries beyond the count are never read, so the
// cells need no reset.

module unique_color_table import uct_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Control state.
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] scan_cnt_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             read_only_r;
  logic             out_valid_r;

  // Request and result payload.
  in_item_t  req_r;
  out_item_t out_r, res;

  // Handshake and operation strobes.
  logic accept;
  logic slot_free;
  logic resp_go;
  logic ins_go;
  logic rem_go;
  logic needs_scan;

  // Chain wiring; element zero feeds the first cell.
  logic             hit_w   [TABLE_DEPTH+1];
  logic [IDX_W-1:0] idx_w   [TABLE_DEPTH+1];
  logic [31:0]      color_w [TABLE_DEPTH];
  logic             bad_index;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Searches always scan; inserts scan only when they may change the table.
  assign needs_scan = (in_data.req_type == REQ_SEARCH) ||
                      ((in_data.req_type == REQ_INSERT) && !read_only_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = needs_scan ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == '0) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    resp_go  = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  in_ready = 1'b0;
      S_RESP:  resp_go  = slot_free;
      default: in_ready = 1'b0;
    endcase
  end

  // The index of a remove is tested against the live count, which never
  // exceeds the depth, so the depth check comes along for free.
  assign bad_index = 32'(req_r.index) >= 32'(count_r);

  // Result and table update for the request in hand.
  always_comb begin
    res       = '{status: ST_OK, found_index: 8'd0, entry_count: 9'd0};
    count_nxt = count_r;
    ins_go    = 1'b0;
    rem_go    = 1'b0;
    if (req_r.req_type == REQ_SEARCH) begin
      if (hit_w[TABLE_DEPTH]) begin
        res.found_index = 8'(idx_w[TABLE_DEPTH]);
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else if (read_only_r) begin
      res.status = ST_READ_ONLY;
    end else begin
      case (req_r.req_type)
        REQ_INSERT: begin
          if (hit_w[TABLE_DEPTH]) begin
            res.status      = ST_PRESENT;
            res.found_index = 8'(idx_w[TABLE_DEPTH]);
          end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            ins_go    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (bad_index) begin
            res.status = ST_BAD_INDEX;
          end else begin
            rem_go    = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_CLEAR: count_nxt = '0;
        default:   count_nxt = count_r;
      endcase
    end
    res.entry_count = 9'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      read_only_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        scan_cnt_r <= IDX_W'(TABLE_DEPTH - 1);
      end else if (state_r == S_SCAN) begin
        scan_cnt_r <= scan_cnt_r - IDX_W'(1);
      end
      if (resp_go) begin
        count_r <= count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        read_only_r <= cfg_data;
      end
      if (resp_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (resp_go) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The chain of cells.
  assign hit_w[0] = 1'b0;
  assign idx_w[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t   ctl;
    logic        live;
    logic [31:0] next_color;

    assign live      = CNT_W'(i) < count_r;
    assign ctl.load  = resp_go && ins_go && (count_r == CNT_W'(i));
    assign ctl.shift = resp_go && rem_go && (i < TABLE_DEPTH - 1) &&
                       (32'(i) >= 32'(req_r.index));

    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign next_color = color_w[i+1];
    end else begin : g_last
      assign next_color = color_w[i];
    end

    uct_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key       (req_r.color),
      .next_color(next_color),
      .live      (live),
      .hit_in    (hit_w[i]),
      .idx_in    (idx_w[i]),
      .hit_out   (hit_w[i+1]),
      .idx_out   (idx_w[i+1]),
      .color_out (color_w[i])
    );
  end

  // The entry count never grows past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH)
    else $error("entry count beyond table depth");

  // A finished request always lands in the output register.
  a_resp_lands: assert property (@(posedge clk) disable iff (!rst_n)
    resp_go |=> out_valid_r)
    else $error("result lost after completion");

  // The table is only modified when a result is produced.
  a_count_only_on_resp: assert property (@(posedge clk) disable iff (!rst_n)
    !resp_go |=> count_r == $past(count_r))
    else $error("entry count changed without a result");

  // A search or insert only answers after the hit has crossed the whole chain.
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && state_nxt == S_RESP) |-> scan_cnt_r == '0)
    else $error("scan ended early");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the unique color table with a scoreboard that predicts every result.
`timescale 1ns / 1ps

import uct_pkg::*;

class color_table_scoreboard #(int DEPTH = 256);
  logic [31:0] colors [DEPTH];
  int unsigned count;
  bit          read_only;
  out_item_t   expected_q [$];
  int unsigned mismatches;

  function new();
    count      = 0;
    read_only  = 1'b0;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Lowest index holding the color, or -1 when it is absent.
  function int find_color(logic [31:0] c);
    for (int i = 0; i < count; i++) begin
      if (colors[i] == c) return i;
    end
    return -1;
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Applies an accepted request to the shadow table and queues its result.
  function void note_request(in_item_t r);
    out_item_t e;
    int        hit;
    e = '{status: ST_OK, found_index: '0, entry_count: '0};
    if (r.req_type == REQ_SEARCH) begin
      hit = find_color(r.color);
      if (hit < 0) e.status = ST_NOT_FOUND;
      else e.found_index = 8'(hit);
    end else if (read_only) begin
      e.status = ST_READ_ONLY;
    end else begin
      case (r.req_type)
        REQ_INSERT: begin
          hit = find_color(r.color);
          if (hit >= 0) begin
            e.status      = ST_PRESENT;
            e.found_index = 8'(hit);
          end else if (count >= DEPTH) begin
            e.status = ST_FULL;
          end else begin
            colors[count] = r.color;
            count++;
          end
        end
        REQ_REMOVE: begin
          if (r.index >= count) begin
            e.status = ST_BAD_INDEX;
          end else begin
            for (int i = r.index; i < count - 1; i++) colors[i] = colors[i + 1];
            count--;
          end
        end
        default: count = 0;
      endcase
    end
    e.entry_count = 9'(count);
    expected_q.push_back(e);
  endfunction

  function void check_result(out_item_t got);
    out_item_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result without a pending request: status %0d index %0d count %0d",
                       got.status, got.found_index, got.entry_count));
      return;
    end
    e = expected_q.pop_front();
    if (got.status !== e.status || got.found_index !== e.found_index ||
        got.entry_count !== e.entry_count) begin
      report($sformatf("result error: expected status %0d index %0d count %0d, %s %0d %0d %0d",
                       e.status, e.found_index, e.entry_count, "got",
                       got.status, got.found_index, got.entry_count));
    end
  endfunction
endclass

module tb;

  localparam int TABLE_DEPTH = 256;
  // Watchdog bound; it leaves several times the slowest legal run with every
  // stall at its longest.
  localparam int CYCLE_LIMIT = 2_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // While set, both the request side and the result side pause at random.
  bit          idle_on = 1'b1;
  logic [31:0] palette [20];
  int unsigned cycles;

  color_table_scoreboard #(TABLE_DEPTH) sb;

  unique_color_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Every result accepted at a rising edge is checked against the oldest
  // prediction. Sampling here sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side back-pressure. Ready drops at random, and now and then it
  // stays high for a long stretch so that results also drain at full rate.
  // With idling off, ready is simply held high.
  initial begin
    int hold;
    int pick;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        out_ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        pick = $urandom_range(0, 11);
        if (pick < 2) begin
          out_ready <= 1'b0;
          hold = $urandom_range(1, 18) - 1;
        end else if (pick == 2) begin
          out_ready <= 1'b1;
          hold = $urandom_range(20, 200) - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Presents one request and holds it until the block takes it. Valid stays
  // high afterwards so that the next request can follow back to back; a
  // random gap lowers it first. The prediction is made at acceptance, so the
  // shadow table is always current when the caller picks the next request.
  task send_request(input req_type_t op, input logic [31:0] color, input logic [7:0] index);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: op, color: color, index: index};
    do @(posedge clk); while (!in_ready);
    sb.note_request('{req_type: op, color: color, index: index});
  endtask

  // Drops the request valid and waits until every predicted result has been
  // seen. Every request yields exactly one result, so the block is idle then.
  task wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Writes the read-only register; only called while the block is idle.
  task write_read_only(input logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.read_only = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fills the table to its last entry with random colors and then works the
  // edges of a full table: the full refusal, a duplicate found deep inside,
  // a hit at the highest index, removes at and past the end, and a remove at
  // the front that shifts every entry down.
  task fill_table();
    logic [31:0] fresh;
    while (sb.count < TABLE_DEPTH) send_request(REQ_INSERT, $urandom(), 8'($urandom()));
    do fresh = $urandom(); while (sb.find_color(fresh) >= 0);
    send_request(REQ_INSERT, fresh, 8'h00);
    send_request(REQ_INSERT, sb.colors[200], 8'hff);
    send_request(REQ_SEARCH, sb.colors[TABLE_DEPTH - 1], 8'h00);
    send_request(REQ_REMOVE, 32'h0, 8'hff);
    send_request(REQ_REMOVE, 32'h0, 8'hff);
    send_request(REQ_INSERT, fresh, 8'h00);
    send_request(REQ_REMOVE, 32'hffff_ffff, 8'h00);
    send_request(REQ_SEARCH, fresh, 8'h00);
    send_request(REQ_CLEAR, 32'h0, 8'h00);
  endtask

  // Random traffic. Colors come mostly from a small palette so that hits and
  // duplicates are common, and most removes name an entry that exists.
  // Clears are rare, which keeps the table populated.
  task run_random(input int n);
    int          pick;
    logic [31:0] color;
    logic [7:0]  index;
    req_type_t   op;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = REQ_SEARCH;
      else if (pick < 75) op = REQ_INSERT;
      else if (pick < 97) op = REQ_REMOVE;
      else op = REQ_CLEAR;
      color = ($urandom_range(0, 3) == 0) ? $urandom() : palette[$urandom_range(0, 19)];
      index = 8'($urandom());
      if (op == REQ_REMOVE && sb.count > 0 && $urandom_range(0, 3) != 0) begin
        index = 8'($urandom_range(0, sb.count - 1));
      end
      send_request(op, color, index);
    end
  endtask

  initial begin
    sb = new();
    palette[0] = 32'h0000_0000;
    palette[1] = 32'hffff_ffff;
    for (int i = 2; i < 20; i++) palette[i] = $urandom();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with writes allowed: misses and bad indexes on an empty
    // table, the extreme colors, a duplicate insert, removes at and beyond
    // the count, and a remove at the front.
    write_read_only(1'b0);
    send_request(REQ_SEARCH, 32'hffff_ffff, 8'h00);
    send_request(REQ_REMOVE, 32'h0, 8'h00);
    send_request(REQ_CLEAR, 32'h0, 8'h00);
    send_request(REQ_INSERT, 32'h0000_0000, 8'h00);
    send_request(REQ_INSERT, 32'hffff_ffff, 8'hff);
    send_request(REQ_INSERT, 32'hffff_ffff, 8'h00);
    send_request(REQ_SEARCH, 32'h0000_0000, 8'hff);
    send_request(REQ_SEARCH, 32'hffff_ffff, 8'h00);
    send_request(REQ_SEARCH, 32'h1234_5678, 8'h00);
    send_request(REQ_REMOVE, 32'h0, 8'hff);
    send_request(REQ_REMOVE, 32'h0, 8'h02);
    send_request(REQ_REMOVE, 32'h0, 8'h00);
    send_request(REQ_SEARCH, 32'hffff_ffff, 8'h00);
    send_request(REQ_INSERT, 32'ha5a5_a5a5, 8'h00);

    // Read-only: searches still work, every change is refused, and the
    // refusal wins over a bad remove index.
    wait_idle();
    write_read_only(1'b1);
    send_request(REQ_SEARCH, 32'ha5a5_a5a5, 8'h00);
    send_request(REQ_INSERT, 32'h5a5a_5a5a, 8'h00);
    send_request(REQ_REMOVE, 32'h0, 8'h00);
    send_request(REQ_REMOVE, 32'h0, 8'hff);
    send_request(REQ_CLEAR, 32'h0, 8'h00);
    wait_idle();
    write_read_only(1'b0);
    send_request(REQ_CLEAR, 32'h0, 8'h00);

    fill_table();

    // Random phases, switching the read-only register between them.
    run_random(300);
    wait_idle();
    write_read_only(1'b1);
    run_random(80);
    wait_idle();
    write_read_only(1'b0);
    run_random(300);
    wait_idle();
    write_read_only(1'b1);
    run_random(40);
    wait_idle();
    write_read_only(1'b0);

    // The closing stretch runs with no idling on either side.
    idle_on = 1'b0;
    run_random(140);
    wait_idle();

    // Let any stray result surface before the verdict.
    repeat (TABLE_DEPTH + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/uct_pkg.sv
rtl/uct_cell.sv
rtl/unique_color_table.sv
tb/tb.sv
